[src/gsvp_pkg.sv]
package gsvp_pkg;

  // Field widths.
  localparam int MV_W    = 12;
  localparam int R0_W    = 24;
  localparam int COEF_W  = 16;
  localparam int THR_W   = 10;
  localparam int CONC_W  = 32;
  localparam int RS_W    = 27;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 2;

  // Register indexes on the configuration port.
  localparam logic [CIDX_W-1:0] REG_REF_RES   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SLOPE     = 2'd1;
  localparam logic [CIDX_W-1:0] REG_INTERCEPT = 2'd2;
  localparam logic [CIDX_W-1:0] REG_THRESHOLD = 2'd3;

  // Register reset values.
  localparam logic [R0_W-1:0]          REF_RES_RST   = 24'd10000;
  localparam logic signed [COEF_W-1:0] SLOPE_RST     = -16'sd1556;
  localparam logic signed [COEF_W-1:0] INTERCEPT_RST = 16'sd2621;
  localparam logic [THR_W-1:0]         THRESHOLD_RST = 10'd10;

  // Divider front end: Rs = floor(DIVIDEND / mv) - RS_OFFSET.
  localparam logic [RS_W-1:0] DIVIDEND  = 27'd100000000;
  localparam logic [RS_W-1:0] RS_OFFSET = 27'd30000;

  // log2(10) in Q.16.
  localparam logic signed [34:0] LOG2_TEN_Q16 = 35'sd217706;

  // Bias that moves log2(ppm) into the Q20.12 output scale.
  localparam logic signed [36:0] OUT_BIAS = 37'sd786432;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DISC = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Floor integer square root of a 64-bit value.
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bt;
    logic [63:0] rem;
    r   = '0;
    bt  = 64'd1 << 62;
    rem = v;
    for (int n = 0; n < 32; n++) begin
      if (rem >= r + bt) begin
        rem = rem - (r + bt);
        r   = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.30, formed by k repeated square roots starting from 2.0.
  function automatic logic [30:0] exp2_factor(input int k);
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int n = 1; n <= 16; n++) begin
      if (n <= k) begin
        c = isqrt(c << 30);
      end
    end
    return c[30:0];
  endfunction

endpackage

[src/gsvp_if.sv]
interface gsvp_in_if;
  logic                       valid;
  logic                       ready;
  logic [gsvp_pkg::MV_W-1:0]  sample_mv;
  modport source (output valid, output sample_mv, input ready);
  modport sink (input valid, input sample_mv, output ready);
endinterface

interface gsvp_out_if;
  logic                        valid;
  logic                        ready;
  logic [gsvp_pkg::CONC_W-1:0] concentration;
  logic [gsvp_pkg::RS_W-1:0]   sensor_resistance;
  logic [1:0]                  status_code;
  modport source (output valid, output concentration, output sensor_resistance,
                  output status_code, input ready);
  modport sink (input valid, input concentration, input sensor_resistance,
                input status_code, output ready);
endinterface

[src/gas_sensor_voltage_to_ppm_unit.sv]
// Gas sensor voltage to ppm converter. Each word on the samples channel is one sensor voltage
// in millivolts; each word on the results channel is its concentration in unsigned Q20.12 ppm
// (saturating), the sensor resistance in ohms and a status code (0 valid, 1 disconnected,
// 2 resistance not positive; both numeric fields read 0 on any error). The unit is a 53-stage
// pipeline that accepts one word per clock while the results side does not stall: a radix-8
// divider for the resistance (9 stages), a squaring log2 unit with one multiplier per
// fraction bit for the sensor and the reference resistance side by side (16 stages), a
// 5-bit-per-stage divider by the slope (7 stages) and an exp2 unit with one constant
// multiply per fraction bit (16 stages). A stall on the results side freezes the whole
// pipeline, so nothing is dropped or repeated. Configuration registers take effect for
// words accepted at any clock edge after the write.
module gas_sensor_voltage_to_ppm_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gsvp_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [gsvp_pkg::CFG_W-1:0]    cfg_data,
  gsvp_in_if.sink                       samples,
  gsvp_out_if.source                    results
);

  localparam int DIV_ST  = 9;
  localparam int DIV_BPS = 3;
  localparam int LOG_ST  = 16;
  localparam int QD_ST   = 7;
  localparam int QD_BPS  = 5;
  localparam int EXP_ST  = 16;

  // Configuration registers.
  logic [gsvp_pkg::R0_W-1:0]          reference_resistance;
  logic signed [gsvp_pkg::COEF_W-1:0] curve_slope;
  logic signed [gsvp_pkg::COEF_W-1:0] curve_intercept;
  logic [gsvp_pkg::THR_W-1:0]         disconnect_threshold_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_resistance    <= gsvp_pkg::REF_RES_RST;
      curve_slope             <= gsvp_pkg::SLOPE_RST;
      curve_intercept         <= gsvp_pkg::INTERCEPT_RST;
      disconnect_threshold_mv <= gsvp_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsvp_pkg::REG_REF_RES:   reference_resistance    <= cfg_data[23:0];
        gsvp_pkg::REG_SLOPE:     curve_slope             <= cfg_data[15:0];
        gsvp_pkg::REG_INTERCEPT: curve_intercept         <= cfg_data[15:0];
        gsvp_pkg::REG_THRESHOLD: disconnect_threshold_mv <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Values derived from configuration; the slope and intercept terms are
  // registered. A zero reference resistance counts as one ohm and a zero slope as minus one LSB.
  logic [gsvp_pkg::R0_W-1:0]          r0_eff;
  logic signed [gsvp_pkg::COEF_W-1:0] m_eff;
  logic signed [34:0]                 b2_prod;
  logic signed [34:0]                 b2_adj;
  logic signed [23:0]                 b2;
  logic [15:0]                        m_abs;
  logic                               m_neg;

  assign r0_eff  = (reference_resistance == '0) ? 24'd1 : reference_resistance;
  assign m_eff   = (curve_slope == '0) ? -16'sd1 : curve_slope;
  assign b2_prod = 35'(curve_intercept) * gsvp_pkg::LOG2_TEN_Q16;
  // Truncation toward zero of the divide by 4096.
  assign b2_adj  = b2_prod + (b2_prod[34] ? 35'sd4095 : 35'sd0);

  always_ff @(posedge clk) begin
    b2    <= 24'(b2_adj >>> 12);
    m_neg <= m_eff[15];
    m_abs <= m_eff[15] ? 16'(-m_eff) : 16'(m_eff);
  end

  function automatic logic [4:0] lead_pos(input logic [26:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 27; i++) begin
      if (x[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  // The whole pipeline moves whenever the output register is free or being taken.
  logic en;
  logic res_v;
  assign en = !res_v || results.ready;
  assign samples.ready = en;

  // ---------------------------------------------------------------------------
  // Resistance divider: floor(1e8 / mv), three quotient bits per stage.
  logic                   dv_v    [0:DIV_ST];
  logic                   dv_disc [0:DIV_ST];
  logic [11:0]            dv_mv   [0:DIV_ST];
  logic [11:0]            dv_rem  [0:DIV_ST];
  logic [26:0]            dv_q    [0:DIV_ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_mv[0]   <= samples.sample_mv;
      dv_disc[0] <= (samples.sample_mv == '0) ||
                    (samples.sample_mv < {2'b00, disconnect_threshold_mv});
      dv_rem[0]  <= '0;
      dv_q[0]    <= '0;
    end
  end

  for (genvar s = 0; s < DIV_ST; s++) begin : g_div
    logic [11:0] rem_c;
    logic [26:0] q_c;
    logic [12:0] wide;
    always_comb begin
      rem_c = dv_rem[s];
      q_c   = dv_q[s];
      wide  = '0;
      for (int j = 0; j < DIV_BPS; j++) begin
        wide = {rem_c, gsvp_pkg::DIVIDEND[26 - (s * DIV_BPS + j)]};
        if (wide >= {1'b0, dv_mv[s]}) begin
          rem_c = 12'(wide - {1'b0, dv_mv[s]});
          q_c   = {q_c[25:0], 1'b1};
        end else begin
          rem_c = wide[11:0];
          q_c   = {q_c[25:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[s+1] <= 1'b0;
      end else if (en) begin
        dv_v[s+1] <= dv_v[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_disc[s+1] <= dv_disc[s];
        dv_mv[s+1]   <= dv_mv[s];
        dv_rem[s+1]  <= rem_c;
        dv_q[s+1]    <= q_c;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Offset, status and normalization of both resistances to Q1.30.
  logic signed [27:0] rs_c;
  logic               rs_bad;
  logic [4:0]         pos_rs;
  logic [4:0]         pos_r0;

  assign rs_c   = $signed({1'b0, dv_q[DIV_ST]}) - $signed({1'b0, gsvp_pkg::RS_OFFSET});
  assign rs_bad = rs_c[27] || (rs_c == '0);
  assign pos_rs = lead_pos(rs_c[26:0]);
  assign pos_r0 = lead_pos({3'b000, r0_eff});

  logic                    lg_v   [0:LOG_ST];
  gsvp_pkg::status_t       lg_st  [0:LOG_ST];
  logic [26:0]             lg_rs  [0:LOG_ST];
  logic [4:0]              lg_nr  [0:LOG_ST];
  logic [4:0]              lg_no  [0:LOG_ST];
  logic [30:0]             lg_yr  [0:LOG_ST];
  logic [30:0]             lg_yo  [0:LOG_ST];
  logic [15:0]             lg_fr  [0:LOG_ST];
  logic [15:0]             lg_fo  [0:LOG_ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_v[0] <= 1'b0;
    end else if (en) begin
      lg_v[0] <= dv_v[DIV_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_disc[DIV_ST]) begin
        lg_st[0] <= gsvp_pkg::ST_DISC;
      end else if (rs_bad) begin
        lg_st[0] <= gsvp_pkg::ST_BAD;
      end else begin
        lg_st[0] <= gsvp_pkg::ST_OK;
      end
      lg_rs[0] <= rs_c[26:0];
      lg_nr[0] <= pos_rs;
      lg_no[0] <= pos_r0;
      lg_yr[0] <= 31'({4'b0000, rs_c[26:0]}) << (5'd30 - pos_rs);
      lg_yo[0] <= 31'({7'b0000000, r0_eff}) << (5'd30 - pos_r0);
      lg_fr[0] <= '0;
      lg_fo[0] <= '0;
    end
  end

  // One squaring per stage and per lane gives one fraction bit of each log2.
  for (genvar k = 0; k < LOG_ST; k++) begin : g_log
    logic [61:0] sq_r;
    logic [61:0] sq_o;
    assign sq_r = {31'b0, lg_yr[k]} * {31'b0, lg_yr[k]};
    assign sq_o = {31'b0, lg_yo[k]} * {31'b0, lg_yo[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        lg_v[k+1] <= 1'b0;
      end else if (en) begin
        lg_v[k+1] <= lg_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lg_st[k+1] <= lg_st[k];
        lg_rs[k+1] <= lg_rs[k];
        lg_nr[k+1] <= lg_nr[k];
        lg_no[k+1] <= lg_no[k];
        lg_yr[k+1] <= sq_r[61] ? sq_r[61:31] : sq_r[60:30];
        lg_yo[k+1] <= sq_o[61] ? sq_o[61:31] : sq_o[60:30];
        lg_fr[k+1] <= {lg_fr[k][14:0], sq_r[61]};
        lg_fo[k+1] <= {lg_fo[k][14:0], sq_o[61]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Numerator log2(Rs) - log2(R0) - b*log2(10), split into sign and magnitude.
  logic signed [23:0] num;
  logic [22:0]        num_abs;

  assign num = $signed({3'b000, lg_nr[LOG_ST], lg_fr[LOG_ST]})
             - $signed({3'b000, lg_no[LOG_ST], lg_fo[LOG_ST]}) - b2;
  assign num_abs = num[23] ? 23'(-num) : num[22:0];

  logic                qd_v   [0:QD_ST];
  gsvp_pkg::status_t   qd_st  [0:QD_ST];
  logic [26:0]         qd_rs  [0:QD_ST];
  logic                qd_neg [0:QD_ST];
  logic [34:0]         qd_dd  [0:QD_ST];
  logic [15:0]         qd_rem [0:QD_ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      qd_v[0] <= 1'b0;
    end else if (en) begin
      qd_v[0] <= lg_v[LOG_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qd_st[0]  <= lg_st[LOG_ST];
      qd_rs[0]  <= lg_rs[LOG_ST];
      qd_neg[0] <= num[23] ^ m_neg;
      qd_dd[0]  <= {num_abs, 12'b0};
      qd_rem[0] <= '0;
    end
  end

  // The dividend register shifts out at the top and takes quotient bits at the bottom.
  for (genvar s = 0; s < QD_ST; s++) begin : g_qdiv
    logic [15:0] rem_c;
    logic [34:0] dd_c;
    logic [16:0] wide;
    always_comb begin
      rem_c = qd_rem[s];
      dd_c  = qd_dd[s];
      wide  = '0;
      for (int j = 0; j < QD_BPS; j++) begin
        wide = {rem_c, dd_c[34]};
        if (wide >= {1'b0, m_abs}) begin
          rem_c = 16'(wide - {1'b0, m_abs});
          dd_c  = {dd_c[33:0], 1'b1};
        end else begin
          rem_c = wide[15:0];
          dd_c  = {dd_c[33:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        qd_v[s+1] <= 1'b0;
      end else if (en) begin
        qd_v[s+1] <= qd_v[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        qd_st[s+1]  <= qd_st[s];
        qd_rs[s+1]  <= qd_rs[s];
        qd_neg[s+1] <= qd_neg[s];
        qd_dd[s+1]  <= dd_c;
        qd_rem[s+1] <= rem_c;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Signed quotient plus the output bias; integer part is the final shift.
  logic signed [36:0] qv;
  logic signed [36:0] t;

  assign qv = qd_neg[QD_ST] ? -$signed({2'b00, qd_dd[QD_ST]}) : $signed({2'b00, qd_dd[QD_ST]});
  assign t  = qv + gsvp_pkg::OUT_BIAS;

  logic                ex_v    [0:EXP_ST];
  gsvp_pkg::status_t   ex_st   [0:EXP_ST];
  logic [26:0]         ex_rs   [0:EXP_ST];
  logic                ex_sat  [0:EXP_ST];
  logic                ex_zero [0:EXP_ST];
  logic [4:0]          ex_i    [0:EXP_ST];
  logic [15:0]         ex_f    [0:EXP_ST];
  logic [30:0]         ex_m    [0:EXP_ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_v[0] <= 1'b0;
    end else if (en) begin
      ex_v[0] <= qd_v[QD_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_st[0]   <= qd_st[QD_ST];
      ex_rs[0]   <= qd_rs[QD_ST];
      ex_zero[0] <= t[36];
      ex_sat[0]  <= !t[36] && (t[35:21] != '0);
      ex_i[0]    <= t[20:16];
      ex_f[0]    <= t[15:0];
      ex_m[0]    <= 31'd1 << 30;
    end
  end

  // Each stage multiplies by 2^(2^-(k+1)) when that fraction bit is set.
  for (genvar k = 0; k < EXP_ST; k++) begin : g_exp
    localparam logic [30:0] FACTOR = gsvp_pkg::exp2_factor(k + 1);
    logic [61:0] prod;
    assign prod = {31'b0, ex_m[k]} * {31'b0, FACTOR};
    always_ff @(posedge clk) begin
      if (rst) begin
        ex_v[k+1] <= 1'b0;
      end else if (en) begin
        ex_v[k+1] <= ex_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ex_st[k+1]   <= ex_st[k];
        ex_rs[k+1]   <= ex_rs[k];
        ex_sat[k+1]  <= ex_sat[k];
        ex_zero[k+1] <= ex_zero[k];
        ex_i[k+1]    <= ex_i[k];
        ex_f[k+1]    <= ex_f[k];
        ex_m[k+1]    <= ex_f[k][15-k] ? prod[60:30] : ex_m[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final scaling into Q20.12, saturation and error masking.
  logic [62:0] shifted;
  logic [32:0] scaled;
  logic [31:0] conc_c;

  assign shifted = {32'b0, ex_m[EXP_ST]} << ex_i[EXP_ST];
  assign scaled  = shifted[62:30];

  always_comb begin
    if (ex_st[EXP_ST] != gsvp_pkg::ST_OK) begin
      conc_c = '0;
    end else if (ex_sat[EXP_ST] || scaled[32]) begin
      conc_c = '1;
    end else if (ex_zero[EXP_ST]) begin
      conc_c = '0;
    end else begin
      conc_c = scaled[31:0];
    end
  end

  logic [31:0]       res_conc;
  logic [26:0]       res_rs;
  gsvp_pkg::status_t res_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (en) begin
      res_v <= ex_v[EXP_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_conc <= conc_c;
      res_rs   <= (ex_st[EXP_ST] == gsvp_pkg::ST_OK) ? ex_rs[EXP_ST] : '0;
      res_st   <= ex_st[EXP_ST];
    end
  end

  assign results.valid             = res_v;
  assign results.concentration     = res_conc;
  assign results.sensor_resistance = res_rs;
  assign results.status_code       = res_st;

  // An accepted sample always lands in the first stage.
  assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> dv_v[0])
    else $error("accepted sample missing from first stage");

  // Any error status forces both numeric fields to zero.
  assert property (@(posedge clk) disable iff (rst)
    res_v && (res_st != gsvp_pkg::ST_OK) |-> (res_conc == '0) && (res_rs == '0))
    else $error("error result carries nonzero data");

  // A valid status implies a positive resistance.
  assert property (@(posedge clk) disable iff (rst)
    res_v && (res_st == gsvp_pkg::ST_OK) |-> (res_rs != '0))
    else $error("valid result with zero resistance");

  // While stalled the last exp stage must not move.
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(ex_m[EXP_ST]) && $stable(ex_v[EXP_ST]))
    else $error("pipeline advanced during stall");

endmodule
